// File: rtl/pbmi_pkg.sv
`timescale 1ns / 1ps

package pbmi_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int WIN_W      = 8;
	localparam int THR_W      = 12;
	localparam int BMAX_W     = 4;
	localparam int BSUM_W     = 16;
	localparam int WSUM_W     = 20;
	localparam int WCNT_W     = 9;
	localparam int BQ8_W      = 20;
	localparam int INTEG_W    = 29;
	localparam int FRAC_W     = 8;
	localparam int DIVD_W     = BSUM_W + FRAC_W;
	localparam int DIV_STEPS  = DIVD_W;
	localparam int STEP_W     = 5;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END     = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_JUMP_THRESHOLD = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BASELINE_MAX   = 8'd3;

	localparam logic [WIN_W-1:0]  RST_WINDOW_START   = 8'd1;
	localparam logic [WIN_W-1:0]  RST_WINDOW_END     = 8'd60;
	localparam logic [THR_W-1:0]  RST_JUMP_THRESHOLD = 12'd5;
	localparam logic [BMAX_W-1:0] RST_BASELINE_MAX   = 4'd10;

	typedef struct packed {
		logic [WIN_W-1:0]  window_start;
		logic [WIN_W-1:0]  window_end;
		logic [THR_W-1:0]  jump_threshold;
		logic [BMAX_W-1:0] baseline_max;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic div_step;
		logic mul_load;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

// File: rtl/pbmi_in_if.sv
`timescale 1ns / 1ps

interface pbmi_in_if import pbmi_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;
	logic                last;

	modport source (output valid, output sample, output last, input ready);
	modport sink (input valid, input sample, input last, output ready);
endinterface

// File: rtl/pbmi_out_if.sv
`timescale 1ns / 1ps

interface pbmi_out_if import pbmi_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [SAMPLE_W-1:0]        peak;
	logic [BQ8_W-1:0]           baseline_q8;
	logic signed [INTEG_W-1:0]  integral_q8;
	logic [BMAX_W-1:0]          baseline_count;

	modport source (output valid, output peak, output baseline_q8, output integral_q8,
		output baseline_count, input ready);
	modport sink (input valid, input peak, input baseline_q8, input integral_q8,
		input baseline_count, output ready);
endinterface

// File: rtl/pbmi_cfg.sv
`timescale 1ns / 1ps

module pbmi_cfg import pbmi_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_start   <= RST_WINDOW_START;
			cfg_q.window_end     <= RST_WINDOW_END;
			cfg_q.jump_threshold <= RST_JUMP_THRESHOLD;
			cfg_q.baseline_max   <= RST_BASELINE_MAX;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_WINDOW_START:   cfg_q.window_start   <= cfg_data[WIN_W-1:0];
				REG_WINDOW_END:     cfg_q.window_end     <= cfg_data[WIN_W-1:0];
				REG_JUMP_THRESHOLD: cfg_q.jump_threshold <= cfg_data[THR_W-1:0];
				REG_BASELINE_MAX:   cfg_q.baseline_max   <= cfg_data[BMAX_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/pbmi_ctrl.sv
`timescale 1ns / 1ps

module pbmi_ctrl import pbmi_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_last,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic [1:0] ST_ACC = 2'd0;
	localparam logic [1:0] ST_DIV = 2'd1;
	localparam logic [1:0] ST_MUL = 2'd2;
	localparam logic [1:0] ST_FIN = 2'd3;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;

	assign in_ready     = (state_q == ST_ACC);
	assign cmd.accept   = in_ready && in_valid;
	assign cmd.div_step = (state_q == ST_DIV);
	assign cmd.mul_load = (state_q == ST_MUL);
	assign cmd.out_load = (state_q == ST_FIN) && status.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_ACC: begin
					step_q <= '0;
					if (cmd.accept && in_last) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_LAST) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (status.out_free) begin
						state_q <= ST_ACC;
					end
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_last_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && in_last |=> state_q == ST_DIV && step_q == '0)
		else $error("Record end did not start the division.");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && step_q == STEP_LAST |=> state_q == ST_MUL)
		else $error("Division did not end after its last step.");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> status.out_free && !in_ready)
		else $error("Result loaded while the output register was busy.");
`endif

endmodule

// File: rtl/pbmi_dp.sv
`timescale 1ns / 1ps

module pbmi_dp import pbmi_pkg::*; #(
	parameter int RECORD_MAX = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  cmd_t                      cmd,
	output status_t                   status,
	input  logic [SAMPLE_W-1:0]       sample,
	input  logic                      last,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic [SAMPLE_W-1:0]       res_peak,
	output logic [BQ8_W-1:0]          res_baseline_q8,
	output logic signed [INTEG_W-1:0] res_integral_q8,
	output logic [BMAX_W-1:0]         res_baseline_count
);

	localparam int IW = $clog2(RECORD_MAX + 1);
	localparam int CW = (IW > WIN_W) ? IW : WIN_W;

	// Record accumulation state.
	logic [IW-1:0]       idx_q;
	logic [SAMPLE_W-1:0] prev_q;
	logic [BSUM_W-1:0]   bsum_q;
	logic [BMAX_W-1:0]   taken_q;
	logic                closed_q;
	logic [SAMPLE_W-1:0] peak_q;
	logic [WSUM_W-1:0]   wsum_q;
	logic [WCNT_W-1:0]   wcnt_q;

	logic [BSUM_W-1:0]   bsum_d;
	logic [BMAX_W-1:0]   taken_d;
	logic                closed_d;
	logic [SAMPLE_W-1:0] peak_d;
	logic [WSUM_W-1:0]   wsum_d;
	logic [WCNT_W-1:0]   wcnt_d;

	logic                in_record;
	logic [SAMPLE_W-1:0] diff;
	logic [BMAX_W-1:0]   taken_inc;
	logic [CW-1:0]       idx_c;

	always_comb begin
		in_record = idx_q < IW'(RECORD_MAX);
		idx_c     = CW'(idx_q);
		diff      = (prev_q > sample) ? (prev_q - sample) : (sample - prev_q);
		taken_inc = taken_q + BMAX_W'(1);
		bsum_d    = bsum_q;
		taken_d   = taken_q;
		closed_d  = closed_q;
		if (in_record && idx_q >= IW'(2) && !closed_q) begin
			if (taken_q < cfg.baseline_max) begin
				bsum_d  = bsum_q + BSUM_W'(prev_q);
				taken_d = taken_inc;
				if (diff > cfg.jump_threshold || taken_inc >= cfg.baseline_max) begin
					closed_d = 1'b1;
				end
			end else begin
				closed_d = 1'b1;
			end
		end
		peak_d = (sample > peak_q) ? sample : peak_q;
		wsum_d = wsum_q;
		wcnt_d = wcnt_q;
		if (in_record && idx_c >= CW'(cfg.window_start) && idx_c <= CW'(cfg.window_end)) begin
			wsum_d = wsum_q + WSUM_W'(sample);
			wcnt_d = wcnt_q + WCNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			prev_q   <= '0;
			bsum_q   <= '0;
			taken_q  <= '0;
			closed_q <= 1'b0;
			peak_q   <= '0;
			wsum_q   <= '0;
			wcnt_q   <= '0;
		end else if (cmd.accept) begin
			if (last) begin
				idx_q    <= '0;
				prev_q   <= '0;
				bsum_q   <= '0;
				taken_q  <= '0;
				closed_q <= 1'b0;
				peak_q   <= '0;
				wsum_q   <= '0;
				wcnt_q   <= '0;
			end else begin
				if (in_record) begin
					idx_q <= idx_q + IW'(1);
				end
				prev_q   <= sample;
				bsum_q   <= bsum_d;
				taken_q  <= taken_d;
				closed_q <= closed_d;
				peak_q   <= peak_d;
				wsum_q   <= wsum_d;
				wcnt_q   <= wcnt_d;
			end
		end
	end

	// Back stage: restoring division, one quotient bit per step, then the product.
	logic [DIVD_W-1:0]   quo_q;
	logic [BMAX_W-1:0]   rem_q;
	logic [BMAX_W-1:0]   divisor_q;
	logic [WSUM_W-1:0]   fin_wsum_q;
	logic [WCNT_W-1:0]   fin_wcnt_q;
	logic [SAMPLE_W-1:0] fin_peak_q;
	logic [INTEG_W-1:0]  prod_q;

	logic [BMAX_W:0]     trial;
	logic                fits;
	logic [BQ8_W-1:0]    bq8;

	assign trial = {rem_q, quo_q[DIVD_W-1]};
	assign fits  = trial >= {1'b0, divisor_q};
	assign bq8   = (divisor_q == '0) ? '0 : quo_q[BQ8_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.accept && last) begin
			quo_q      <= {bsum_d, FRAC_W'(0)};
			rem_q      <= '0;
			divisor_q  <= taken_d;
			fin_wsum_q <= wsum_d;
			fin_wcnt_q <= wcnt_d;
			fin_peak_q <= peak_d;
		end else if (cmd.div_step) begin
			if (fits) begin
				rem_q <= BMAX_W'(trial - {1'b0, divisor_q});
				quo_q <= {quo_q[DIVD_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[BMAX_W-1:0];
				quo_q <= {quo_q[DIVD_W-2:0], 1'b0};
			end
		end
		if (cmd.mul_load) begin
			prod_q <= INTEG_W'(fin_wcnt_q) * INTEG_W'(bq8);
		end
	end

	// Output register.
	logic                      res_valid_q;
	logic [SAMPLE_W-1:0]       res_peak_q;
	logic [BQ8_W-1:0]          res_bq8_q;
	logic signed [INTEG_W-1:0] res_integ_q;
	logic [BMAX_W-1:0]         res_count_q;

	assign status.out_free = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_peak_q  <= fin_peak_q;
			res_bq8_q   <= bq8;
			res_integ_q <= $signed(INTEG_W'({fin_wsum_q, FRAC_W'(0)}) - prod_q);
			res_count_q <= divisor_q;
		end
	end

	assign res_valid          = res_valid_q;
	assign res_peak           = res_peak_q;
	assign res_baseline_q8    = res_bq8_q;
	assign res_integral_q8    = res_integ_q;
	assign res_baseline_count = res_count_q;

endmodule

// File: rtl/pulse_baseline_max_integral.sv
`timescale 1ns / 1ps
// Samples are taken one per cycle while a record is being accumulated.
// After the transfer of the last sample the block takes no sample until it has
// run a 24-step restoring division, the multiply and the output load.
// The result becomes valid after the output load, which waits while the
// previous result has not been taken. Reset clears the record state, the
// output valid and sets the configuration registers to their defaults.

module pulse_baseline_max_integral import pbmi_pkg::*; #(
	parameter int RECORD_MAX = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	pbmi_in_if.sink               sample_ch,
	pbmi_out_if.source            result_ch
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	pbmi_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	pbmi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample_ch.valid),
		.in_last  (sample_ch.last),
		.in_ready (sample_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	pbmi_dp #(
		.RECORD_MAX (RECORD_MAX)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg),
		.cmd                (cmd),
		.status             (status),
		.sample             (sample_ch.sample),
		.last               (sample_ch.last),
		.res_valid          (result_ch.valid),
		.res_ready          (result_ch.ready),
		.res_peak           (result_ch.peak),
		.res_baseline_q8    (result_ch.baseline_q8),
		.res_integral_q8    (result_ch.integral_q8),
		.res_baseline_count (result_ch.baseline_count)
	);

endmodule
